>>> hw/rtl/tftp_pkg.sv
// Shared types, codes and constants for the TFTP read-transfer sender.
package tftp_pkg;

   // payload and config widths
   localparam int LEN_W      = 10;
   localparam int BLK_W      = 16;
   localparam int OFF_W      = 32;
   localparam int BSIZE_W    = 16;
   localparam int SENDS_W    = 8;
   localparam int TICKS_W    = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [BSIZE_W-1:0] MAX_BLOCK_BYTES = 16'd512;
   localparam logic [15:0]        ACK_OPCODE      = 16'd4;
   localparam logic [15:0]        MIN_ACK_LENGTH  = 16'd4;

   // request command codes
   localparam logic [1:0] CMD_START  = 2'd0;
   localparam logic [1:0] CMD_PACKET = 2'd1;
   localparam logic [1:0] CMD_TICK   = 2'd2;

   // classified item codes
   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_ACK   = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_SEND = 2'd0;
   localparam logic [1:0] KIND_DONE = 2'd1;
   localparam logic [1:0] KIND_FAIL = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_SIZE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SENDS     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_TICKS = 2'd2;

   localparam logic [BSIZE_W-1:0] RST_BLOCK_SIZE    = 16'd512;
   localparam logic [SENDS_W-1:0] RST_MAX_SENDS     = 8'd5;
   localparam logic [TICKS_W-1:0] RST_TIMEOUT_TICKS = 16'd300;

   // queue sizes
   localparam int CMDQ_AW    = 2;
   localparam int CMDQ_DEPTH = 1 << CMDQ_AW;
   localparam int RSPQ_AW    = 1;
   localparam int RSPQ_DEPTH = 1 << RSPQ_AW;

   typedef struct packed {
      logic [1:0]       op;
      logic [OFF_W-1:0] file_length;
      logic [BLK_W-1:0] rx_block;
   } item_type;

   typedef struct packed {
      logic [1:0]       result_kind;
      logic [BLK_W-1:0] block_number;
      logic [OFF_W-1:0] byte_offset;
      logic [LEN_W-1:0] payload_length;
      logic [OFF_W-1:0] bytes_done;
   } rsp_type;

   // payload length of the next block: min(remaining, block size), low bits kept
   function automatic logic [LEN_W-1:0] clip_len(input logic [OFF_W-1:0] rem,
                                                 input logic [BSIZE_W-1:0] bs);
      logic [OFF_W-1:0] bs_w;
      bs_w = {{(OFF_W-BSIZE_W){1'b0}}, bs};
      return (rem < bs_w) ? rem[LEN_W-1:0] : bs_w[LEN_W-1:0];
   endfunction

endpackage

>>> hw/rtl/tftp_front.sv
// Front end: classifies requests, drops those with no effect, queues the rest.
module tftp_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  logic [1:0]           req_command,
   input  logic [31:0]          req_file_length,
   input  logic [15:0]          req_rx_length,
   input  logic [15:0]          req_rx_opcode,
   input  logic [15:0]          req_rx_block,
   output logic                 item_valid,
   output tftp_pkg::item_type   item,
   input  logic                 item_pop
);

   tftp_pkg::item_type                 q_mem_ff [tftp_pkg::CMDQ_DEPTH];
   logic [tftp_pkg::CMDQ_AW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [tftp_pkg::CMDQ_AW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [tftp_pkg::CMDQ_AW:0]         cnt_ff, cnt_in;
   logic                               accept;
   logic                               keep;
   logic                               enq;
   tftp_pkg::item_type                 cls;

   assign full   = (cnt_ff == (tftp_pkg::CMDQ_AW+1)'(tftp_pkg::CMDQ_DEPTH));
   assign accept = push && !full;

   always_comb begin
      keep            = 1'b0;
      cls.op          = tftp_pkg::OP_TICK;
      cls.file_length = req_file_length;
      cls.rx_block    = req_rx_block;
      unique case (req_command)
         tftp_pkg::CMD_START: begin
            keep   = 1'b1;
            cls.op = tftp_pkg::OP_START;
         end
         tftp_pkg::CMD_PACKET: begin
            // malformed or non-ACK packets never change state
            keep   = (req_rx_length >= tftp_pkg::MIN_ACK_LENGTH) &&
                     (req_rx_opcode == tftp_pkg::ACK_OPCODE);
            cls.op = tftp_pkg::OP_ACK;
         end
         tftp_pkg::CMD_TICK: begin
            keep   = 1'b1;
            cls.op = tftp_pkg::OP_TICK;
         end
         default: keep = 1'b0;
      endcase
   end

   assign enq        = accept && keep;
   assign item_valid = (cnt_ff != '0);
   assign item       = q_mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = enq ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = item_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      case ({enq, item_pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         q_mem_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

>>> hw/rtl/tftp_back.sv
// Back end: transfer state, timeout and retry handling, result queue, registers.
module tftp_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [1:0]            csr_index,
   input  logic [15:0]           csr_wdata,
   input  logic                  item_valid,
   input  tftp_pkg::item_type    item,
   output logic                  item_pop,
   output logic                  empty,
   input  logic                  pop,
   output tftp_pkg::rsp_type     rsp
);

   // registers, held already clamped
   logic [tftp_pkg::BSIZE_W-1:0] bsize_ff;
   logic [tftp_pkg::SENDS_W-1:0] max_sends_ff;
   logic [tftp_pkg::TICKS_W-1:0] timeout_ff;

   logic                         busy_ff, busy_in;
   logic [tftp_pkg::BLK_W-1:0]   blk_ff, blk_in;
   logic [tftp_pkg::OFF_W-1:0]   off_ff, off_in;
   logic [tftp_pkg::LEN_W-1:0]   len_ff, len_in;
   logic [tftp_pkg::OFF_W-1:0]   rem_ff, rem_in;
   logic [tftp_pkg::SENDS_W-1:0] sends_ff, sends_in;
   logic [tftp_pkg::TICKS_W-1:0] wait_ff, wait_in;
   logic [tftp_pkg::OFF_W-1:0]   acked_ff, acked_in;

   logic [tftp_pkg::OFF_W-1:0]   len_w;
   logic [tftp_pkg::OFF_W-1:0]   acked_sum;
   logic [tftp_pkg::OFF_W-1:0]   rem_dec;
   logic [tftp_pkg::TICKS_W-1:0] wait_inc;

   logic                         res_valid;
   tftp_pkg::rsp_type            res;

   tftp_pkg::rsp_type            rq_mem_ff [tftp_pkg::RSPQ_DEPTH];
   logic [tftp_pkg::RSPQ_AW-1:0] rq_wr_ff, rq_rd_ff;
   logic [tftp_pkg::RSPQ_AW:0]   rq_cnt_ff, rq_cnt_in;
   logic                         rq_deq;
   logic                         out_room;

   assign empty    = (rq_cnt_ff == '0);
   assign rsp      = rq_mem_ff[rq_rd_ff];
   assign rq_deq   = pop && !empty;
   assign out_room = (rq_cnt_ff != (tftp_pkg::RSPQ_AW+1)'(tftp_pkg::RSPQ_DEPTH)) || rq_deq;
   assign item_pop = item_valid && out_room;

   always_ff @(posedge clock) begin
      if (reset) begin
         bsize_ff     <= tftp_pkg::RST_BLOCK_SIZE;
         max_sends_ff <= tftp_pkg::RST_MAX_SENDS;
         timeout_ff   <= tftp_pkg::RST_TIMEOUT_TICKS;
      end else if (csr_wr_en) begin
         case (csr_index)
            tftp_pkg::CSR_BLOCK_SIZE: begin
               if (csr_wdata == '0 || csr_wdata > tftp_pkg::MAX_BLOCK_BYTES) begin
                  bsize_ff <= tftp_pkg::MAX_BLOCK_BYTES;
               end else begin
                  bsize_ff <= csr_wdata;
               end
            end
            tftp_pkg::CSR_MAX_SENDS: begin
               max_sends_ff <= (csr_wdata[7:0] == '0) ? 8'd1 : csr_wdata[7:0];
            end
            tftp_pkg::CSR_TIMEOUT_TICKS: begin
               timeout_ff <= (csr_wdata == '0) ? 16'd1 : csr_wdata;
            end
            default: ;
         endcase
      end
   end

   assign len_w     = {{(tftp_pkg::OFF_W-tftp_pkg::LEN_W){1'b0}}, len_ff};
   assign acked_sum = acked_ff + len_w;
   assign rem_dec   = rem_ff - ((rem_ff < len_w) ? rem_ff : len_w);
   assign wait_inc  = (wait_ff == '1) ? wait_ff : wait_ff + 1'b1;

   always_comb begin
      busy_in   = busy_ff;
      blk_in    = blk_ff;
      off_in    = off_ff;
      len_in    = len_ff;
      rem_in    = rem_ff;
      sends_in  = sends_ff;
      wait_in   = wait_ff;
      acked_in  = acked_ff;
      res_valid = 1'b0;
      res       = '0;
      if (item_pop) begin
         unique case (item.op)
            tftp_pkg::OP_START: begin
               busy_in   = 1'b1;
               blk_in    = 16'd1;
               off_in    = '0;
               acked_in  = '0;
               rem_in    = item.file_length;
               len_in    = tftp_pkg::clip_len(item.file_length, bsize_ff);
               sends_in  = 8'd1;
               wait_in   = '0;
               res_valid = 1'b1;
               res.result_kind    = tftp_pkg::KIND_SEND;
               res.block_number   = 16'd1;
               res.payload_length = len_in;
            end
            tftp_pkg::OP_ACK: begin
               if (busy_ff && item.rx_block == blk_ff) begin
                  acked_in  = acked_sum;
                  rem_in    = rem_dec;
                  res_valid = 1'b1;
                  res.bytes_done = acked_sum;
                  if ({{(tftp_pkg::BSIZE_W-tftp_pkg::LEN_W){1'b0}}, len_ff} < bsize_ff) begin
                     // short block: transfer complete
                     busy_in         = 1'b0;
                     res.result_kind = tftp_pkg::KIND_DONE;
                  end else begin
                     off_in   = off_ff + len_w;
                     blk_in   = blk_ff + 1'b1;
                     len_in   = tftp_pkg::clip_len(rem_dec, bsize_ff);
                     sends_in = 8'd1;
                     wait_in  = '0;
                     res.result_kind    = tftp_pkg::KIND_SEND;
                     res.block_number   = blk_in;
                     res.byte_offset    = off_in;
                     res.payload_length = len_in;
                  end
               end
            end
            tftp_pkg::OP_TICK: begin
               if (busy_ff) begin
                  wait_in = wait_inc;
                  if (wait_inc >= timeout_ff) begin
                     res_valid      = 1'b1;
                     res.bytes_done = acked_ff;
                     if (sends_ff >= max_sends_ff) begin
                        busy_in         = 1'b0;
                        res.result_kind = tftp_pkg::KIND_FAIL;
                     end else begin
                        sends_in = (sends_ff == '1) ? sends_ff : sends_ff + 1'b1;
                        wait_in  = '0;
                        res.result_kind    = tftp_pkg::KIND_SEND;
                        res.block_number   = blk_ff;
                        res.byte_offset    = off_ff;
                        res.payload_length = len_ff;
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      case ({res_valid, rq_deq})
         2'b10:   rq_cnt_in = rq_cnt_ff + 1'b1;
         2'b01:   rq_cnt_in = rq_cnt_ff - 1'b1;
         default: rq_cnt_in = rq_cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         blk_ff    <= '0;
         off_ff    <= '0;
         len_ff    <= '0;
         rem_ff    <= '0;
         sends_ff  <= '0;
         wait_ff   <= '0;
         acked_ff  <= '0;
         rq_wr_ff  <= '0;
         rq_rd_ff  <= '0;
         rq_cnt_ff <= '0;
      end else begin
         busy_ff   <= busy_in;
         blk_ff    <= blk_in;
         off_ff    <= off_in;
         len_ff    <= len_in;
         rem_ff    <= rem_in;
         sends_ff  <= sends_in;
         wait_ff   <= wait_in;
         acked_ff  <= acked_in;
         rq_cnt_ff <= rq_cnt_in;
         if (res_valid) begin
            rq_wr_ff <= rq_wr_ff + 1'b1;
         end
         if (rq_deq) begin
            rq_rd_ff <= rq_rd_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rq_mem_ff[rq_wr_ff] <= res;
      end
   end

endmodule

>>> hw/rtl/tftp_read_sender.sv
// A request that yields a result goes through the request queue, then the result queue;
// both are registered. Throughput: one request per cycle while full is low; the back end
// retires one queued item per cycle while the result queue has room.
// A 4-entry request queue and 2-entry result queue let either side stall independently.
// Reset is synchronous: clears the transfer state and both queues and restores
// register defaults (block size 512, 5 sends, 300 ticks). No clearing pass.
module tftp_read_sender (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_command,
   input  logic [31:0] req_file_length,
   input  logic [15:0] req_rx_length,
   input  logic [15:0] req_rx_opcode,
   input  logic [15:0] req_rx_block,
   output logic        empty,
   input  logic        pop,
   output logic [1:0]  rsp_result_kind,
   output logic [15:0] rsp_block_number,
   output logic [31:0] rsp_byte_offset,
   output logic [9:0]  rsp_payload_length,
   output logic [31:0] rsp_bytes_done,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   logic               item_valid;
   logic               item_pop;
   tftp_pkg::item_type item;
   tftp_pkg::rsp_type  rsp;

   tftp_front u_front (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_command     (req_command),
      .req_file_length (req_file_length),
      .req_rx_length   (req_rx_length),
      .req_rx_opcode   (req_rx_opcode),
      .req_rx_block    (req_rx_block),
      .item_valid      (item_valid),
      .item            (item),
      .item_pop        (item_pop)
   );

   tftp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .empty      (empty),
      .pop        (pop),
      .rsp        (rsp)
   );

   assign rsp_result_kind    = rsp.result_kind;
   assign rsp_block_number   = rsp.block_number;
   assign rsp_byte_offset    = rsp.byte_offset;
   assign rsp_payload_length = rsp.payload_length;
   assign rsp_bytes_done     = rsp.bytes_done;

endmodule
